### hdl/seeded_xorshift_shuffle_core_defines.svh
// Assertion macros for the seeded shuffle core.
// Included by the top level; no other dependencies.
`ifndef SEEDED_XORSHIFT_SHUFFLE_CORE_DEFINES_SVH
`define SEEDED_XORSHIFT_SHUFFLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SXS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define SXS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SXS_ASSERT(label, prop, msg)
`define SXS_ASSERT_RST(label, prop, msg)
`endif
`endif

### hdl/sxs_pkg.sv
// Shared constants, types and the xorshift32 step for the shuffle core.
// No dependencies.
package sxs_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int DATA_W    = 32;
    localparam int ELEM_W    = 8;
    localparam int STREAM_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM = 1'd1;

    localparam logic [DATA_W-1:0] GOLDEN_MUL    = 32'h9E37_79B9;
    localparam logic [DATA_W-1:0] ZERO_SEED_FIX = 32'h0123_4567;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [DATA_W-1:0] xs_next(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

### hdl/sxs_in_if.sv
// Input channel: one list element per beat.
// Depends on sxs_pkg.
interface sxs_in_if;
    logic                        valid;
    logic                        ready;
    logic [sxs_pkg::ELEM_W-1:0]  element;
    logic                        is_final;

    modport source(output valid, output element, output is_final, input ready);
    modport sink(input valid, input element, input is_final, output ready);
endinterface

### hdl/sxs_out_if.sv
// Output channel: one permuted element per beat.
// Depends on sxs_pkg.
interface sxs_out_if;
    logic                        valid;
    logic                        ready;
    logic [sxs_pkg::ELEM_W-1:0]  out_element;
    logic                        out_final;
    logic                        overflowed;

    modport source(output valid, output out_element, output out_final,
                   output overflowed, input ready);
    modport sink(input valid, input out_element, input out_final,
                 input overflowed, output ready);
endinterface

### hdl/sxs_divider.sv
// Bit-serial restoring remainder unit: 32-bit dividend by a small divisor.
// One quotient bit per cycle; depends on sxs_pkg.
module sxs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sxs_pkg::t_div_req i_req,
    output sxs_pkg::t_div_rsp o_rsp
);
    import sxs_pkg::*;

    logic [DATA_W-1:0]    r_dividend;
    logic [CNT_W-1:0]     r_divisor;
    logic [CNT_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [CNT_W:0]       w_shift;
    logic [CNT_W:0]       w_diff;
    logic                 w_ge;

    assign w_shift = {r_rem, r_dividend[DATA_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_divisor};
    assign w_diff  = w_shift - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dividend <= i_req.dividend;
            r_divisor  <= i_req.divisor;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
endmodule

### hdl/sxs_store.sv
// Element store: one write port, two registered read ports.
// Depends on sxs_pkg.
module sxs_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [sxs_pkg::IDX_W-1:0]  i_waddr,
    input  logic [sxs_pkg::ELEM_W-1:0] i_wdata,
    input  logic [sxs_pkg::IDX_W-1:0]  i_raddr_a,
    input  logic [sxs_pkg::IDX_W-1:0]  i_raddr_b,
    output logic [sxs_pkg::ELEM_W-1:0] o_rdata_a,
    output logic [sxs_pkg::ELEM_W-1:0] o_rdata_b
);
    import sxs_pkg::*;

    logic [ELEM_W-1:0] r_mem [MAX_ITEMS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

### hdl/seeded_xorshift_shuffle_core.sv
// Seeded shuffle core: load, Fisher-Yates permute, emit.
// Depends on sxs_pkg, sxs_in_if, sxs_out_if, sxs_divider, sxs_store.
//
// Usage:
//   i_in_ch takes one element per beat; the beat with is_final closes the list.
//   Up to 64 elements are held; further ones are dropped and overflowed is
//   then 1 on every result beat of that list.
//   o_out_ch returns the permuted list in order, out_final on the last beat.
//   Config (seed, stream_index) is written through i_cfg_we/i_cfg_idx/i_cfg_data
//   while idle; it takes effect at the next shuffle start.
// Timing:
//   Load: one element per cycle while i_in_ch.ready is high. After the final
//   beat: a seed setup state, then n-1 swaps, each made of a xorshift step,
//   the bit-serial remainder unit, a store read and two writes. Emit: each
//   element is read from the store, loaded into the result register and
//   held until the receiver takes it; the next store read starts only then.
//   i_in_ch.ready is low from the final beat until the last result is taken.
// Reset: synchronous; clears the list, overflow flag and config registers.
// Stall: a result beat holds on o_out_ch until ready; the block waits.
`include "seeded_xorshift_shuffle_core_defines.svh"
module seeded_xorshift_shuffle_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sxs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sxs_pkg::DATA_W-1:0]    i_cfg_data,
    sxs_in_if.sink                        i_in_ch,
    sxs_out_if.source                     o_out_ch
);
    import sxs_pkg::*;

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_SEED = 4'd1;
    localparam logic [3:0] ST_STEP = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_RD   = 4'd4;
    localparam logic [3:0] ST_WR1  = 4'd5;
    localparam logic [3:0] ST_WR2  = 4'd6;
    localparam logic [3:0] ST_ER   = 4'd7;
    localparam logic [3:0] ST_EL   = 4'd8;
    localparam logic [3:0] ST_EW   = 4'd9;

    logic [3:0]          r_state, n_state;
    logic [DATA_W-1:0]   r_seed;
    logic [STREAM_W-1:0] r_stream;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [DATA_W-1:0]   r_rand, n_rand;
    logic [IDX_W-1:0]    r_hi, n_hi;
    logic [IDX_W-1:0]    r_j, n_j;
    logic [IDX_W-1:0]    r_k, n_k;
    logic [ELEM_W-1:0]   r_tmp, n_tmp;
    logic                r_out_valid, n_out_valid;
    logic [ELEM_W-1:0]   r_out_elem, n_out_elem;
    logic                r_out_final, n_out_final;

    logic                w_in_acc;
    logic                w_out_acc;
    logic [DATA_W-1:0]   w_mix;
    logic [DATA_W-1:0]   w_seed;
    logic [DATA_W-1:0]   w_xs;

    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [ELEM_W-1:0]   w_wdata;
    logic [IDX_W-1:0]    w_raddr_a;
    logic [ELEM_W-1:0]   w_rdata_a;
    logic [ELEM_W-1:0]   w_rdata_b;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    assign i_in_ch.ready = (r_state == ST_LOAD);
    assign w_in_acc      = i_in_ch.valid && (r_state == ST_LOAD);
    assign w_out_acc     = r_out_valid && o_out_ch.ready;

    assign w_mix  = r_seed ^ (GOLDEN_MUL * (DATA_W'(r_stream) + DATA_W'(1)));
    assign w_seed = (w_mix != '0) ? w_mix : ZERO_SEED_FIX;
    assign w_xs   = xs_next(r_rand);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_rand      = r_rand;
        n_hi        = r_hi;
        n_j         = r_j;
        n_k         = r_k;
        n_tmp       = r_tmp;
        n_out_valid = r_out_valid;
        n_out_elem  = r_out_elem;
        n_out_final = r_out_final;
        w_we        = 1'b0;
        w_waddr     = r_hi;
        w_wdata     = w_rdata_b;
        w_raddr_a   = r_hi;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_xs;
        w_div_req.divisor  = CNT_W'(r_hi) + CNT_W'(1);

        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[IDX_W-1:0];
                        w_wdata = i_in_ch.element;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_ch.is_final) begin
                        n_state = ST_SEED;
                    end
                end
            end
            ST_SEED: begin
                n_rand = w_seed;
                n_hi   = IDX_W'(r_count - CNT_W'(1));
                n_k    = '0;
                n_state = (r_count == CNT_W'(1)) ? ST_ER : ST_STEP;
            end
            ST_STEP: begin
                n_rand          = w_xs;
                w_div_req.start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_j     = w_div_rsp.rem[IDX_W-1:0];
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_WR1;
            end
            ST_WR1: begin
                w_we    = 1'b1;
                w_waddr = r_hi;
                w_wdata = w_rdata_b;
                n_tmp   = w_rdata_a;
                n_state = ST_WR2;
            end
            ST_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_tmp;
                if (r_hi == IDX_W'(1)) begin
                    n_k     = '0;
                    n_state = ST_ER;
                end else begin
                    n_hi    = r_hi - IDX_W'(1);
                    n_state = ST_STEP;
                end
            end
            ST_ER: begin
                w_raddr_a = r_k;
                n_state   = ST_EL;
            end
            ST_EL: begin
                n_out_valid = 1'b1;
                n_out_elem  = w_rdata_a;
                n_out_final = (CNT_W'(r_k) + CNT_W'(1) == r_count);
                n_state     = ST_EW;
            end
            ST_EW: begin
                if (w_out_acc) begin
                    n_out_valid = 1'b0;
                    if (r_out_final) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = ST_ER;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_seed      <= '0;
            r_stream    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SEED:   r_seed   <= i_cfg_data;
                    REG_STREAM: r_stream <= i_cfg_data[STREAM_W-1:0];
                    default:    r_seed   <= r_seed;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rand      <= n_rand;
        r_hi        <= n_hi;
        r_j         <= n_j;
        r_k         <= n_k;
        r_tmp       <= n_tmp;
        r_out_elem  <= n_out_elem;
        r_out_final <= n_out_final;
    end

    sxs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    sxs_store u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (r_j),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.out_element = r_out_elem;
    assign o_out_ch.out_final   = r_out_final;
    assign o_out_ch.overflowed  = r_ovf;

    `SXS_ASSERT(a_no_load_during_emit, !(i_in_ch.ready && o_out_ch.valid), "input open during emit")
    `SXS_ASSERT(a_rem_in_range, w_div_rsp.done |-> (w_div_rsp.rem <= CNT_W'(r_hi)), "swap index out of range")
    `SXS_ASSERT(a_div_idle_in_load, (r_state == ST_LOAD) |-> !w_div_rsp.busy, "divider busy while loading")
    `SXS_ASSERT(a_final_returns_to_load, (w_out_acc && r_out_final) |=> ((r_state == ST_LOAD) && (r_count == '0)), "list not cleared after final beat")
    `SXS_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_out_ch.valid, "result valid after reset")
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for seeded_xorshift_shuffle_core: lists in, permuted lists out.
// Depends on sxs_pkg, sxs_in_if, sxs_out_if and the core; predicts each shuffle itself.
module testbench;
    import sxs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEM_TARGET = 280;
    localparam int NUM_PHASES  = 6;
    localparam int SETTLE_CYC  = 8;
    localparam int TAIL_CYC    = 40;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic              fin;
        logic              ovf;
    } t_shuffled_beat;

    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic              fin;
        logic              typed;
        t_shuffled_beat    want;
    } t_dir_row;

    // typed rows are single-element lists, each starting from an empty list
    localparam int NUM_ROWS = 18;
    localparam t_dir_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{8'h5A, 1'b1, 1'b1, '{8'h5A, 1'b1, 1'b0}},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h34, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0},
        '{8'hA5, 1'b1, 1'b1, '{8'hA5, 1'b1, 1'b0}},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h04, 1'b0, 1'b0, '0},
        '{8'h08, 1'b0, 1'b0, '0},
        '{8'h10, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b0, '0},
        '{8'h40, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b0}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;

    sxs_in_if  in_ch();
    sxs_out_if out_ch();

    seeded_xorshift_shuffle_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    always #10 i_clk = ~i_clk;

    logic [DATA_W-1:0] cfg_seed;
    logic [ELEM_W-1:0] cfg_stream;
    logic [ELEM_W-1:0] held_elems[$];
    logic              held_overflow;
    t_shuffled_beat    pending_beats[$];
    logic              quiet_run = 1'b0;

    int unsigned items_sent    = 0;
    int unsigned lists_done    = 0;
    int unsigned overflow_lists = 0;
    int unsigned beats_checked = 0;
    int unsigned err_count     = 0;
    int unsigned cycle_count   = 0;

    logic [DATA_W-1:0] phase_seed   [NUM_PHASES];
    logic [ELEM_W-1:0] phase_stream [NUM_PHASES];

    task automatic absorb_element(input logic [ELEM_W-1:0] elem, input logic fin);
        logic [DATA_W-1:0] rs;
        logic [ELEM_W-1:0] t;
        int unsigned       n;
        int unsigned       j;
        if (held_elems.size() < MAX_ITEMS) begin
            held_elems.push_back(elem);
        end else begin
            held_overflow = 1'b1;
        end
        if (fin) begin
            rs = cfg_seed ^ 32'(GOLDEN_MUL * (32'(cfg_stream) + 32'd1));
            if (rs == '0) begin
                rs = ZERO_SEED_FIX;
            end
            n = held_elems.size();
            for (int unsigned i = n; i > 1; i--) begin
                rs = rs ^ (rs << 13);
                rs = rs ^ (rs >> 17);
                rs = rs ^ (rs << 5);
                j = rs % i;
                t = held_elems[i-1];
                held_elems[i-1] = held_elems[j];
                held_elems[j] = t;
            end
            for (int unsigned k = 0; k < n; k++) begin
                pending_beats.push_back(t_shuffled_beat'{held_elems[k], k + 1 == n,
                                                         held_overflow});
            end
            lists_done++;
            if (held_overflow) begin
                overflow_lists++;
            end
            held_elems.delete();
            held_overflow = 1'b0;
        end
    endtask

    task automatic send_beat(input logic [ELEM_W-1:0] elem, input logic fin);
        if (!quiet_run && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.element  <= elem;
        in_ch.is_final <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic run_list(input int unsigned len);
        logic [ELEM_W-1:0] elem;
        for (int unsigned k = 0; k < len; k++) begin
            elem = ELEM_W'($urandom_range(0, 255));
            send_beat(elem, k + 1 == len);
            absorb_element(elem, k + 1 == len);
        end
    endtask

    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == REG_SEED) begin
            cfg_seed = data;
        end else begin
            cfg_stream = data[ELEM_W-1:0];
        end
    endtask

    // receiver stalls in bursts
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 11);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_shuffled_beat got_beat;
        t_shuffled_beat want_beat;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_beat = '{out_ch.out_element, out_ch.out_final, out_ch.overflowed};
            if (pending_beats.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("%t: unexpected beat elem=%h final=%b ovf=%b", $time,
                             got_beat.elem, got_beat.fin, got_beat.ovf);
                end
            end else begin
                want_beat = pending_beats.pop_front();
                beats_checked++;
                if (got_beat != want_beat) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%t: mismatch exp elem=%h final=%b ovf=%b, got elem=%h final=%b ovf=%b",
                                 $time, want_beat.elem, want_beat.fin, want_beat.ovf,
                                 got_beat.elem, got_beat.fin, got_beat.ovf);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%t: timeout, %0d beats still expected", $time, pending_beats.size());
            $display("seeded_xorshift_shuffle_core regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_SEED;
        i_cfg_data     <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.element  <= '0;
        in_ch.is_final <= 1'b0;
        cfg_seed       = '0;
        cfg_stream     = '0;
        held_overflow  = 1'b0;

        phase_seed[0] = GOLDEN_MUL;                        phase_stream[0] = 8'd0;
        phase_seed[1] = 32'hFFFF_FFFF;                     phase_stream[1] = 8'hFF;
        phase_seed[2] = 32'h0;                             phase_stream[2] = 8'hFF;
        phase_seed[3] = 32'(GOLDEN_MUL * 32'd256);         phase_stream[3] = 8'hFF;
        phase_seed[4] = $urandom;                          phase_stream[4] = 8'($urandom);
        phase_seed[5] = $urandom;                          phase_stream[5] = 8'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_beat(DIRECTED_ROWS[r].elem, DIRECTED_ROWS[r].fin);
            if (DIRECTED_ROWS[r].typed) begin
                pending_beats.push_back(DIRECTED_ROWS[r].want);
            end else begin
                absorb_element(DIRECTED_ROWS[r].elem, DIRECTED_ROWS[r].fin);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_and_settle();
            write_reg(REG_SEED, phase_seed[p]);
            write_reg(REG_STREAM, {(DATA_W - ELEM_W)'($urandom), phase_stream[p]});
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            quiet_run = (p == NUM_PHASES - 1);
            // full capacity, then one past it so the final beat is dropped
            if (p == 0) begin
                run_list(MAX_ITEMS);
            end else if (p == 1) begin
                run_list(MAX_ITEMS + 1);
            end
            do begin
                int unsigned pick;
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    run_list($urandom_range(1, 8));
                end else if (pick < 97) begin
                    run_list($urandom_range(9, 24));
                end else begin
                    run_list($urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 3));
                end
            end while (items_sent < NUM_ROWS + (p + 1) * (ITEM_TARGET - NUM_ROWS) / NUM_PHASES);
        end

        drain_and_settle();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (pending_beats.size() != 0) begin
            $display("%t: %0d permuted beats never arrived", $time, pending_beats.size());
        end
        $display("%0d elements in %0d lists (%0d overflowed) over %0d seed settings",
                 items_sent, lists_done, overflow_lists, NUM_PHASES + 1);
        $display("%0d permuted beats checked, %0d errors", beats_checked, err_count);
        if (err_count == 0 && pending_beats.size() == 0) begin
            $display("seeded_xorshift_shuffle_core regression: pass");
        end else begin
            $display("seeded_xorshift_shuffle_core regression: fail");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/sxs_pkg.sv
hdl/sxs_in_if.sv
hdl/sxs_out_if.sv
hdl/sxs_divider.sv
hdl/sxs_store.sv
hdl/seeded_xorshift_shuffle_core.sv
tb/sv/testbench.sv
